>>> src/ata_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_pkg
// Shared widths, register indexes and the arctangent table for the tilt core.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int SampleW = 16;
  localparam int SumW    = 32;
  localparam int RootW   = 32;
  localparam int RemW    = 35;
  localparam int CordW   = 36;
  localparam int AngW    = 24;
  localparam int MaxStages = 24;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_OFFSET_X       = 3'd0;
  localparam reg_idx_t REG_OFFSET_Y       = 3'd1;
  localparam reg_idx_t REG_OFFSET_Z       = 3'd2;
  localparam reg_idx_t REG_ANGLE_OFFSET_X = 3'd3;
  localparam reg_idx_t REG_ANGLE_OFFSET_Y = 3'd4;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [AngW-1:0] atan_q16(input int i);
    logic signed [AngW-1:0] v;
    case (i)
      0:  v = 24'sd2949120;
      1:  v = 24'sd1740967;
      2:  v = 24'sd919879;
      3:  v = 24'sd466945;
      4:  v = 24'sd234379;
      5:  v = 24'sd117304;
      6:  v = 24'sd58666;
      7:  v = 24'sd29335;
      8:  v = 24'sd14668;
      9:  v = 24'sd7334;
      10: v = 24'sd3667;
      11: v = 24'sd1833;
      12: v = 24'sd917;
      13: v = 24'sd458;
      14: v = 24'sd229;
      15: v = 24'sd115;
      16: v = 24'sd57;
      17: v = 24'sd29;
      18: v = 24'sd14;
      19: v = 24'sd7;
      20: v = 24'sd4;
      21: v = 24'sd2;
      22: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/ata_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_sqrt_cell
// One bit of a pipelined restoring square root, numerator carried alongside.
// ----------------------------------------------------------------------------
module ata_sqrt_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ata_pkg::SumW-1:0]          rad_in,
  input  logic [ata_pkg::RemW-1:0]          rem_in,
  input  logic [ata_pkg::RootW-1:0]         root_in,
  input  logic signed [ata_pkg::SampleW-1:0] num_in,
  output logic [ata_pkg::SumW-1:0]          rad,
  output logic [ata_pkg::RemW-1:0]          rem,
  output logic [ata_pkg::RootW-1:0]         root,
  output logic signed [ata_pkg::SampleW-1:0] num
);

  logic [ata_pkg::RemW+1:0] rem_sh;
  logic [ata_pkg::RemW+1:0] trial;
  logic [ata_pkg::RemW+1:0] diff;
  logic                     take;

  always_comb begin
    rem_sh = {rem_in, rad_in[ata_pkg::SumW-1 -: 2]};
    trial  = {{(ata_pkg::RemW-ata_pkg::RootW){1'b0}}, root_in, 2'b01};
    take   = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= {rad_in[ata_pkg::SumW-3:0], 2'b00};
      num <= num_in;
      if (take) begin
        rem  <= diff[ata_pkg::RemW-1:0];
        root <= {root_in[ata_pkg::RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[ata_pkg::RemW-1:0];
        root <= {root_in[ata_pkg::RootW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> src/ata_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_cordic_cell
// One vectoring-mode CORDIC rotation with its fixed shift and angle.
// ----------------------------------------------------------------------------
module ata_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ata_pkg::CordW-1:0] x_in,
  input  logic signed [ata_pkg::CordW-1:0] y_in,
  input  logic signed [ata_pkg::AngW-1:0]  z_in,
  output logic signed [ata_pkg::CordW-1:0] x,
  output logic signed [ata_pkg::CordW-1:0] y,
  output logic signed [ata_pkg::AngW-1:0]  z
);

  localparam logic signed [ata_pkg::AngW-1:0] Atan = ata_pkg::atan_q16(IDX);

  logic signed [ata_pkg::CordW-1:0] dx;
  logic signed [ata_pkg::CordW-1:0] dy;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[ata_pkg::CordW-1]) begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + Atan;
      end else begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - Atan;
      end
    end
  end

endmodule

>>> src/accel_tilt_angles_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_core
// Tilt angles asin(x/|a|) and asin(y/|a|) from a three-axis acceleration.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample is taken every cycle while s_axis_tready is high;
// each passes through the offset add, squares, sums, 32 square-root bit
// cells, the CORDIC cells, then rounding and offset.
// Every stage fills a bubble ahead of it, so a stalled output only blocks
// the input once the pipeline is full. Angles are in 2^-ANGLE_FRAC_BITS
// degree and saturate to 16 bits; an all-zero corrected vector sets
// zero_vector and returns the angle offsets.
module accel_tilt_angles_core #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // tilt_x, tilt_y
  output logic        m_axis_tuser,   // zero_vector
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int NCord = (CORDIC_STAGES < ata_pkg::MaxStages) ? CORDIC_STAGES
                                                              : ata_pkg::MaxStages;
  localparam int NSqrt = ata_pkg::RootW;
  localparam int SqBase = 3;
  localparam int CdBase = SqBase + NSqrt;
  localparam int NSt = CdBase + NCord + 1;
  localparam int Sh = 16 - ANGLE_FRAC_BITS;
  localparam logic [ata_pkg::AngW:0] Half = (ata_pkg::AngW+1)'(1) << (Sh - 1);

  // config registers
  logic signed [15:0] offset_x, offset_y, offset_z, angle_offset_x, angle_offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x       <= '0;
      offset_y       <= '0;
      offset_z       <= '0;
      angle_offset_x <= '0;
      angle_offset_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ata_pkg::REG_OFFSET_X:       offset_x       <= cfg_data;
        ata_pkg::REG_OFFSET_Y:       offset_y       <= cfg_data;
        ata_pkg::REG_OFFSET_Z:       offset_z       <= cfg_data;
        ata_pkg::REG_ANGLE_OFFSET_X: angle_offset_x <= cfg_data;
        ata_pkg::REG_ANGLE_OFFSET_Y: angle_offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage valid, zero flag and advance enable
  logic [NSt-1:0] vld;
  logic [NSt-1:0] zro;
  logic [NSt-1:0] en;

  assign en[NSt-1] = !vld[NSt-1] || m_axis_tready;
  for (genvar k = 0; k < NSt - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];

  // offset add, wrapping
  logic signed [15:0] cx, cy, cz;
  logic signed [15:0] cx_next, cy_next, cz_next;
  logic               zro_next;

  assign cx_next  = s_axis_tdata[15:0]  + offset_x;
  assign cy_next  = s_axis_tdata[31:16] + offset_y;
  assign cz_next  = s_axis_tdata[47:32] + offset_z;
  assign zro_next = (cx_next == '0) && (cy_next == '0) && (cz_next == '0);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cx <= cx_next;
      cy <= cy_next;
      cz <= cz_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) zro[0] <= zro_next;
    for (int k = 1; k < NSt; k++) begin
      if (en[k]) zro[k] <= zro[k-1];
    end
  end

  // squares
  logic [31:0] xx, yy, zz;
  logic signed [15:0] nx1, ny1;
  logic signed [31:0] px, py, pz;

  assign px = cx * cx;
  assign py = cy * cy;
  assign pz = cz * cz;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xx  <= px;
      yy  <= py;
      zz  <= pz;
      nx1 <= cx;
      ny1 <= cy;
    end
  end

  // sums of squares
  logic [ata_pkg::SumW-1:0] sum_a, sum_b;
  logic signed [15:0] nx2, ny2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum_a <= xx + zz;
      sum_b <= yy + zz;
      nx2   <= nx1;
      ny2   <= ny1;
    end
  end

  // square-root rows: row a for tilt_x (num y), row b for tilt_y (num x)
  logic [ata_pkg::SumW-1:0]  ra_rad [0:NSqrt];
  logic [ata_pkg::RemW-1:0]  ra_rem [0:NSqrt];
  logic [ata_pkg::RootW-1:0] ra_root[0:NSqrt];
  logic signed [15:0]        ra_num [0:NSqrt];
  logic [ata_pkg::SumW-1:0]  rb_rad [0:NSqrt];
  logic [ata_pkg::RemW-1:0]  rb_rem [0:NSqrt];
  logic [ata_pkg::RootW-1:0] rb_root[0:NSqrt];
  logic signed [15:0]        rb_num [0:NSqrt];

  assign ra_rad[0]  = sum_a;
  assign ra_rem[0]  = '0;
  assign ra_root[0] = '0;
  assign ra_num[0]  = ny2;
  assign rb_rad[0]  = sum_b;
  assign rb_rem[0]  = '0;
  assign rb_root[0] = '0;
  assign rb_num[0]  = nx2;

  for (genvar j = 0; j < NSqrt; j++) begin : g_sqrt
    ata_sqrt_cell u_sq_a (
      .clk(clk), .en(en[SqBase+j]),
      .rad_in(ra_rad[j]), .rem_in(ra_rem[j]), .root_in(ra_root[j]), .num_in(ra_num[j]),
      .rad(ra_rad[j+1]), .rem(ra_rem[j+1]), .root(ra_root[j+1]), .num(ra_num[j+1])
    );
    ata_sqrt_cell u_sq_b (
      .clk(clk), .en(en[SqBase+j]),
      .rad_in(rb_rad[j]), .rem_in(rb_rem[j]), .root_in(rb_root[j]), .num_in(rb_num[j]),
      .rad(rb_rad[j+1]), .rem(rb_rem[j+1]), .root(rb_root[j+1]), .num(rb_num[j+1])
    );
  end

  // cordic rows
  logic signed [ata_pkg::CordW-1:0] ca_x[0:NCord];
  logic signed [ata_pkg::CordW-1:0] ca_y[0:NCord];
  logic signed [ata_pkg::AngW-1:0]  ca_z[0:NCord];
  logic signed [ata_pkg::CordW-1:0] cb_x[0:NCord];
  logic signed [ata_pkg::CordW-1:0] cb_y[0:NCord];
  logic signed [ata_pkg::AngW-1:0]  cb_z[0:NCord];

  assign ca_x[0] = {{(ata_pkg::CordW-ata_pkg::RootW){1'b0}}, ra_root[NSqrt]};
  assign ca_y[0] = {{(ata_pkg::CordW-32){ra_num[NSqrt][15]}}, ra_num[NSqrt], 16'h0000};
  assign ca_z[0] = '0;
  assign cb_x[0] = {{(ata_pkg::CordW-ata_pkg::RootW){1'b0}}, rb_root[NSqrt]};
  assign cb_y[0] = {{(ata_pkg::CordW-32){rb_num[NSqrt][15]}}, rb_num[NSqrt], 16'h0000};
  assign cb_z[0] = '0;

  for (genvar k = 0; k < NCord; k++) begin : g_cord
    ata_cordic_cell #(.IDX(k)) u_cd_a (
      .clk(clk), .en(en[CdBase+k]),
      .x_in(ca_x[k]), .y_in(ca_y[k]), .z_in(ca_z[k]),
      .x(ca_x[k+1]), .y(ca_y[k+1]), .z(ca_z[k+1])
    );
    ata_cordic_cell #(.IDX(k)) u_cd_b (
      .clk(clk), .en(en[CdBase+k]),
      .x_in(cb_x[k]), .y_in(cb_y[k]), .z_in(cb_z[k]),
      .x(cb_x[k+1]), .y(cb_y[k+1]), .z(cb_z[k+1])
    );
  end

  // rounding half away from zero, offset, saturation
  function automatic logic signed [15:0] finish(input logic signed [ata_pkg::AngW-1:0] z,
                                                input logic signed [15:0] offs);
    logic [ata_pkg::AngW:0]   mag;
    logic [ata_pkg::AngW:0]   rm;
    logic signed [ata_pkg::AngW+1:0] r;
    logic signed [ata_pkg::AngW+1:0] s;
    logic signed [15:0]       res;
    mag = z[ata_pkg::AngW-1] ? -{z[ata_pkg::AngW-1], z} : {1'b0, z};
    rm  = (mag + Half) >> Sh;
    r   = z[ata_pkg::AngW-1] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
    s   = r + offs;
    if (s > 32767) res = 16'sh7fff;
    else if (s < -32768) res = 16'sh8000;
    else res = s[15:0];
    return res;
  endfunction

  logic signed [15:0] tilt_x, tilt_y;

  always_ff @(posedge clk) begin
    if (en[NSt-1]) begin
      if (zro[NSt-2]) begin
        tilt_x <= angle_offset_x;
        tilt_y <= angle_offset_y;
      end else begin
        tilt_x <= finish(ca_z[NCord], angle_offset_x);
        tilt_y <= finish(cb_z[NCord], angle_offset_y);
      end
    end
  end

  assign m_axis_tvalid = vld[NSt-1];
  assign m_axis_tdata  = {tilt_y, tilt_x};
  assign m_axis_tuser  = zro[NSt-1];

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted sample missing from first stage");

  a_ready_only_blocked_when_full : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> vld[0] && vld[NSt-1] && !m_axis_tready)
    else $error("input blocked while pipeline has room");

  a_stall_keeps_tail : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready && vld[NSt-2] |=> vld[NSt-2] && m_axis_tvalid)
    else $error("item lost behind stalled output");

endmodule

>>> sim/accel_tilt_angles_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_core_test
// Self-checking bench for the tilt angle core: offsets, angles and zero vector.
// Samples go in through the request stream with random bursts and gaps. Each
// returned angle pair is compared with a behavioural CORDIC model in order.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core_test;

  localparam int FracBits = 8;
  localparam int Stages   = 16;
  localparam int Latency  = 36 + Stages;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [15:0] tilt_x;
    logic [15:0] tilt_y;
    logic        zero_vector;
  } tilt_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] ofs_x, ofs_y, ofs_z, ang_ofs_x, ang_ofs_y;
  tilt_t       tilt_q[$];
  int          mismatches = 0;
  int          hold_off = 0;
  int          stall_reqs = 0;
  int          stall_seen = 0;
  int          gap_len = 0;

  always #4 clk = ~clk;

  accel_tilt_angles_core #(.ANGLE_FRAC_BITS(FracBits), .CORDIC_STAGES(Stages)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] tilt_angle(input longint num, input longint a,
                                             input longint b, input longint offs);
    longint cx, cy, zz, dx, dy, half, r;
    int     sh;
    cx = longint'(int_sqrt(longint'(a * a + b * b) << 32));
    cy = num * 65536;
    zz = 0;
    for (int i = 0; i < Stages && i < ata_pkg::MaxStages; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; zz += longint'(ata_pkg::atan_q16(i));
      end else begin
        cx -= dx; cy += dy; zz -= longint'(ata_pkg::atan_q16(i));
      end
    end
    sh   = 16 - FracBits;
    half = longint'(1) << (sh - 1);
    r    = (zz >= 0) ? ((zz + half) >>> sh) : -((-zz + half) >>> sh);
    r += offs;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic tilt_t predict_tilt(input logic [15:0] ax, input logic [15:0] ay,
                                         input logic [15:0] az);
    logic signed [15:0] x, y, z;
    tilt_t t;
    x = ax + ofs_x;
    y = ay + ofs_y;
    z = az + ofs_z;
    if (x == 0 && y == 0 && z == 0) begin
      t = '{ang_ofs_x, ang_ofs_y, 1'b1};
    end else begin
      t.tilt_x = tilt_angle(y, x, z, longint'($signed(ang_ofs_x)));
      t.tilt_y = tilt_angle(x, y, z, longint'($signed(ang_ofs_y)));
      t.zero_vector = 1'b0;
    end
    return t;
  endfunction

  task automatic write_reg(input ata_pkg::reg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_addr = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      ata_pkg::REG_OFFSET_X:       ofs_x = val;
      ata_pkg::REG_OFFSET_Y:       ofs_y = val;
      ata_pkg::REG_OFFSET_Z:       ofs_z = val;
      ata_pkg::REG_ANGLE_OFFSET_X: ang_ofs_x = val;
      ata_pkg::REG_ANGLE_OFFSET_Y: ang_ofs_y = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (tilt_q.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [15:0] oz, input logic [15:0] aox,
                            input logic [15:0] aoy);
    drain();
    write_reg(ata_pkg::REG_OFFSET_X, ox);
    write_reg(ata_pkg::REG_OFFSET_Y, oy);
    write_reg(ata_pkg::REG_OFFSET_Z, oz);
    write_reg(ata_pkg::REG_ANGLE_OFFSET_X, aox);
    write_reg(ata_pkg::REG_ANGLE_OFFSET_Y, aoy);
  endtask

  // caller is at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
    if (gap_len > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap_len) @(negedge clk);
      gap_len = 0;
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {az, ay, ax};
    do @(posedge clk); while (!s_axis_tready);
    tilt_q.push_back(predict_tilt(ax, ay, az));
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_random(input int n, input bit small_vec);
    logic [15:0] ax, ay, az;
    for (int i = 0; i < n; i++) begin
      if (small_vec) begin
        ax = 16'($urandom_range(0, 8)) - 16'd4 - ofs_x;
        ay = 16'($urandom_range(0, 8)) - 16'd4 - ofs_y;
        az = 16'($urandom_range(0, 8)) - 16'd4 - ofs_z;
      end else begin
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      end
      // bursts: occasional random gap before a request
      if ($urandom_range(0, 7) == 0) gap_len = $urandom_range(1, 12);
      send_sample(ax, ay, az);
    end
  endtask

  task automatic test_directed;
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h7FFF, 16'h0000);
    send_sample(16'h0000, 16'h8000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h7FFF);
    send_sample(16'h0000, 16'h0000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'hFFFF, 16'h0001, 16'hFFFF);
    send_sample(16'h4000, 16'hC000, 16'h1234);
    // offset wrap and zero vector produced by the offsets
    set_config(16'h7FFF, 16'h8000, 16'h0001, 16'd23040, 16'hA600);
    send_sample(16'h0001, 16'hFFFF, 16'h0000);
    send_sample(16'h8001, 16'h8000, 16'hFFFF);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h0000, 16'hFFFF);
    // out-of-range register index is ignored
    drain();
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd7, 16'h1234);
    send_sample(16'h1000, 16'h2000, 16'h3000);
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                      16'd23040, 16'd23040);
        2: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                      -16'sd23040, -16'sd23040);
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom_range(0, 46080)) - 16'd23040,
                            16'($urandom_range(0, 46080)) - 16'd23040);
      endcase
      send_random(200, 1'b0);
      send_random(60, 1'b1);
    end
  endtask

  task automatic test_backpressure;
    drain();
    stall_reqs++;
    for (int i = 0; i < 120; i++)
      send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
  endtask

  // receiver stall pattern plus optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_reqs != stall_seen) begin
      stall_seen    <= stall_reqs;
      hold_off      <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off      <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    tilt_t exp_t;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (tilt_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_t = tilt_q.pop_front();
        if (m_axis_tdata[15:0] !== exp_t.tilt_x || m_axis_tdata[31:16] !== exp_t.tilt_y ||
            m_axis_tuser !== exp_t.zero_vector) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%b got x=%h y=%h z=%b",
                     exp_t.tilt_x, exp_t.tilt_y, exp_t.zero_vector,
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
        end
      end
    end
  end

  initial begin
    ofs_x = 0; ofs_y = 0; ofs_z = 0; ang_ofs_x = 0; ang_ofs_y = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && tilt_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
